[rtl/modbus_rtu_frame_delimiter_top_defines.svh]
// assertion macros for the modbus rtu frame delimiter
// expects clk and arst_n in the scope where a macro is used
`ifndef MODBUS_RTU_FRAME_DELIMITER_TOP_DEFINES_SVH
`define MODBUS_RTU_FRAME_DELIMITER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MRFD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MRFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mrfd_pkg.sv]
// shared types and constants for the modbus rtu frame delimiter
// no dependencies
package mrfd_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_HEAD    = 3'd1,
		PH_COUNT   = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_ECHO    = 3'd4,
		PH_EXC     = 3'd5,
		PH_CRC     = 3'd6
	} phase_t;

	// completion status codes
	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_SHORT_HEADER  = 3'd1,
		ST_UNKNOWN_CODE  = 3'd2,
		ST_BAD_COUNT     = 3'd3,
		ST_SHORT_PAYLOAD = 3'd4,
		ST_SHORT_ECHO    = 3'd5,
		ST_BAD_EXCEPTION = 3'd6,
		ST_SHORT_CRC     = 3'd7
	} status_t;

	// input event kinds
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_GAP  = 1'b1;

	// configuration register indexes
	localparam logic [0:0] REG_DIRECTION_MODE = 1'd0;
	localparam logic [0:0] REG_BUFFER_LIMIT   = 1'd1;

	localparam logic [9:0] BUFFER_LIMIT_RESET = 10'd256;

	// function codes
	localparam logic [7:0] FC_READ_COILS     = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
	localparam logic [7:0] FC_READ_INPUT     = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
	localparam logic [7:0] FC_WRITE_REGISTER = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS     = 8'd16;
	localparam logic [7:0] EXC_FLAG          = 8'h80;

	// frame geometry
	localparam logic [7:0] HDR_LEN_REQ  = 8'd6;
	localparam logic [7:0] HDR_LEN_RSP  = 8'd2;
	localparam logic [9:0] CNT_RED_REQ  = 10'd10;
	localparam logic [9:0] CNT_RED_RSP  = 10'd5;
	localparam logic [8:0] FIXED_BODY   = 9'd6;
	localparam logic [8:0] CRC_LEN      = 9'd2;
	localparam logic [7:0] CRC_LEN_CNT  = 8'd2;

	// one input transaction
	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} item_t;

	// one result transaction
	typedef struct packed {
		logic [7:0] data_out;
		logic [8:0] byte_position;
		logic       frame_done;
		status_t    status;
		logic [8:0] frame_length;
		logic [7:0] phase_count;
	} result_t;

endpackage

[rtl/modbus_rtu_frame_delimiter_top.sv]
// modbus rtu frame delimiter: usage
// input channel item_valid/item_ready/item carries one event per transaction:
//   a received byte (req_type 0) or an inter-byte gap timeout (req_type 1)
// output channel result_valid/result_ready/result echoes each byte with its
//   position; frame_done marks the last byte or an error, with status,
//   frame_length and phase_count
// config channel cfg_valid/cfg_ready/cfg_index/cfg_wdata writes direction_mode
//   (index 0) and buffer_limit (index 1); cfg_ready is always high, and
//   writes are meant to happen only while no frame is in flight
// an accepted event passes through the input register, then the result
//   register, on its way to the result channel
// throughput: one event per cycle unless the result register stalls; the frame
//   state register updates in the cycle the event leaves the input register
// a gap while no frame is open makes no result
// a stalled receiver holds the result register, and the input register
//   fills behind it; item_ready drops once both are full
// reset clears the parser to idle, direction_mode to 0, buffer_limit to 256
// depends on mrfd_pkg and modbus_rtu_frame_delimiter_top_defines.svh
`include "modbus_rtu_frame_delimiter_top_defines.svh"

module modbus_rtu_frame_delimiter_top
	import mrfd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  item_t         item,
	output logic          result_valid,
	input  logic          result_ready,
	output result_t       result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [0:0]    cfg_index,
	input  logic [9:0]    cfg_wdata
);

	// configuration registers
	logic       direction_mode_q;
	logic [9:0] buffer_limit_q;

	// frame state
	phase_t     phase_q, phase_d;
	logic [8:0] pos_q, pos_d;
	logic [7:0] pcnt_q, pcnt_d;
	logic [7:0] fc_q, fc_d;
	logic [8:0] body_end_q, body_end_d;

	// input stage and result register
	logic    s1_valid_q;
	item_t   item_s1;
	logic    result_valid_q;
	result_t result_q;

	logic    advance;
	logic    gap;
	logic    is_idle;
	logic [7:0] b;
	phase_t  cur_phase;
	logic [7:0] pcnt_inc;
	logic [8:0] pos_inc;
	logic [9:0] pos_p1;
	logic [7:0] fc_eff;
	logic [7:0] hlen;
	logic       head_end;
	logic [9:0] red;
	logic [9:0] cnt_sum;
	logic       count_ok;
	logic       payload_end;
	logic       crc_end;
	phase_t     hd_phase;
	logic       hd_fixed;
	logic       hd_unknown;
	logic       res_gen;
	logic       res_done;
	result_t    res_c;

	// handshake
	assign advance      = s1_valid_q && (!result_valid_q || result_ready);
	assign item_ready   = !s1_valid_q || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_mode_q <= 1'b0;
			buffer_limit_q   <= BUFFER_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DIRECTION_MODE: direction_mode_q <= cfg_wdata[0];
				REG_BUFFER_LIMIT:   buffer_limit_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_valid && item_ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// shared per-event terms
	assign gap       = (item_s1.req_type == REQ_GAP);
	assign b         = item_s1.data_byte;
	assign is_idle   = (phase_q == PH_IDLE);
	assign cur_phase = is_idle ? PH_HEAD : phase_q;
	assign pcnt_inc  = (is_idle ? 8'd0 : pcnt_q) + 8'd1;
	assign pos_inc   = pos_q + 9'd1;
	assign pos_p1    = {1'b0, pos_q} + 10'd1;
	assign fc_eff    = (pos_q == 9'd1) ? b : fc_q;
	assign hlen      = direction_mode_q ? HDR_LEN_RSP : HDR_LEN_REQ;
	assign head_end  = (pcnt_inc >= hlen);
	assign red       = direction_mode_q ? CNT_RED_RSP : CNT_RED_REQ;
	assign cnt_sum   = {2'b00, b} + red;
	assign count_ok  = (b != 8'd0) && (cnt_sum < buffer_limit_q);
	assign payload_end = (pos_p1 >= {1'b0, body_end_q});
	assign crc_end   = (pcnt_inc >= CRC_LEN_CNT);

	// function code decode at the end of the header
	always_comb begin
		hd_phase   = PH_CRC;
		hd_fixed   = 1'b0;
		hd_unknown = 1'b0;
		if (!direction_mode_q) begin
			unique case (fc_eff) inside
				FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
				FC_WRITE_COIL, FC_WRITE_REGISTER: begin
					hd_phase = PH_CRC;
					hd_fixed = 1'b1;
				end
				FC_WRITE_COILS, FC_WRITE_REGS: begin
					hd_phase = PH_COUNT;
				end
				default: begin
					hd_unknown = 1'b1;
				end
			endcase
		end else if ((fc_eff & EXC_FLAG) != 8'd0) begin
			hd_phase = PH_EXC;
		end else begin
			unique case (fc_eff) inside
				FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: begin
					hd_phase = PH_COUNT;
				end
				FC_WRITE_COIL, FC_WRITE_REGISTER, FC_WRITE_COILS, FC_WRITE_REGS: begin
					hd_phase = PH_ECHO;
					hd_fixed = 1'b1;
				end
				default: begin
					hd_unknown = 1'b1;
				end
			endcase
		end
	end

	// result fields
	always_comb begin
		res_gen             = 1'b1;
		res_c.data_out      = b;
		res_c.byte_position = pos_q;
		res_c.frame_done    = 1'b0;
		res_c.status        = ST_OK;
		res_c.frame_length  = 9'd0;
		res_c.phase_count   = 8'd0;
		if (gap) begin
			res_gen             = !is_idle;
			res_c.data_out      = 8'd0;
			res_c.frame_done    = 1'b1;
			res_c.phase_count   = pcnt_q;
			unique case (phase_q)
				PH_HEAD:    res_c.status = ST_SHORT_HEADER;
				PH_COUNT:   res_c.status = ST_BAD_COUNT;
				PH_PAYLOAD: res_c.status = ST_SHORT_PAYLOAD;
				PH_ECHO:    res_c.status = ST_SHORT_ECHO;
				PH_EXC:     res_c.status = ST_BAD_EXCEPTION;
				PH_CRC:     res_c.status = ST_SHORT_CRC;
				default:    res_c.status = ST_OK;
			endcase
		end else begin
			unique case (cur_phase)
				PH_HEAD: begin
					if (head_end && hd_unknown) begin
						res_c.frame_done = 1'b1;
						res_c.status     = ST_UNKNOWN_CODE;
					end
				end
				PH_COUNT: begin
					if (!count_ok) begin
						res_c.frame_done  = 1'b1;
						res_c.status      = ST_BAD_COUNT;
						res_c.phase_count = b;
					end
				end
				PH_EXC: begin
					if (b == 8'd0) begin
						res_c.frame_done = 1'b1;
						res_c.status     = ST_BAD_EXCEPTION;
					end
				end
				PH_CRC: begin
					if (crc_end) begin
						res_c.frame_done   = 1'b1;
						res_c.frame_length = body_end_q + CRC_LEN;
					end
				end
				default: ;
			endcase
		end
		res_done = res_c.frame_done;
	end

	// next frame state
	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		pcnt_d     = pcnt_q;
		fc_d       = fc_q;
		body_end_d = body_end_q;
		if (!gap) begin
			phase_d = cur_phase;
			pos_d   = pos_inc;
			pcnt_d  = pcnt_inc;
			unique case (cur_phase)
				PH_HEAD: begin
					if (pos_q == 9'd1) begin
						fc_d = b;
					end
					if (head_end && !hd_unknown) begin
						phase_d = hd_phase;
						pcnt_d  = 8'd0;
						if (hd_fixed) begin
							body_end_d = FIXED_BODY;
						end
					end
				end
				PH_COUNT: begin
					if (count_ok) begin
						phase_d    = PH_PAYLOAD;
						pcnt_d     = 8'd0;
						body_end_d = pos_inc + {1'b0, b};
					end
				end
				PH_PAYLOAD, PH_ECHO: begin
					if (payload_end) begin
						phase_d = PH_CRC;
						pcnt_d  = 8'd0;
					end
				end
				PH_EXC: begin
					if (b != 8'd0) begin
						phase_d    = PH_CRC;
						pcnt_d     = 8'd0;
						body_end_d = pos_inc;
					end
				end
				default: ;
			endcase
		end
		// completion or error returns the parser to idle
		if (res_done) begin
			phase_d    = PH_IDLE;
			pos_d      = 9'd0;
			pcnt_d     = 8'd0;
			fc_d       = 8'd0;
			body_end_d = 9'd0;
		end
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pos_q      <= 9'd0;
			pcnt_q     <= 8'd0;
			fc_q       <= 8'd0;
			body_end_q <= 9'd0;
		end else if (advance) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			pcnt_q     <= pcnt_d;
			fc_q       <= fc_d;
			body_end_q <= body_end_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && res_gen) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_gen) begin
			result_q <= res_c;
		end
	end

	// checks on the parser
	`MRFD_ASSERT_IMP(a_open_result_clean, result_valid_q && !result_q.frame_done, result_q.status == ST_OK && result_q.frame_length == 9'd0 && result_q.phase_count == 8'd0, "open-frame result carries completion fields")
	`MRFD_ASSERT_NEXT(a_done_to_idle, advance && res_gen && res_done, phase_q == PH_IDLE && pos_q == 9'd0, "parser not idle after frame end")
	`MRFD_ASSERT_IMP(a_idle_counters, phase_q == PH_IDLE, pos_q == 9'd0 && pcnt_q == 8'd0 && body_end_q == 9'd0, "counters not cleared while idle")

endmodule

[bench/mrfd_frame_checker.sv]
// frame checker for the modbus rtu frame delimiter: predicts each result from
// the observed input and config transactions and compares it field by field
// depends on mrfd_pkg
module mrfd_frame_checker
	import mrfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_ready,
	input  item_t      item,
	input  logic       result_valid,
	input  logic       result_ready,
	input  result_t    result,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [9:0] cfg_wdata,
	output int         outstanding,
	output int         fail_count
);

	// predicted frame state and register copies
	phase_t     phase;
	logic [8:0] pos_cnt;
	logic [7:0] phase_cnt;
	logic [7:0] func_code;
	logic [8:0] crc_start;
	logic       rsp_mode;
	logic [9:0] count_limit;

	result_t    expected_results[$];
	int         result_count = 0;
	int         errors = 0;

	assign fail_count = errors;

	task automatic report_mismatch(input string msg);
		$display("ERROR %s", msg);
		errors++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				result_count, name, got, want));
	endtask

	function automatic void clear_frame();
		phase     = PH_IDLE;
		pos_cnt   = '0;
		phase_cnt = '0;
		func_code = '0;
		crc_start = '0;
	endfunction

	function automatic void enter_phase(input phase_t next);
		phase     = next;
		phase_cnt = '0;
	endfunction

	// advance the frame state by one event, returns 1 when a result is due
	function automatic bit predict_frame_event(input item_t ev, output result_t r);
		logic [8:0] pos;
		logic [7:0] b;
		int         hdr_len;
		int         reduce;
		r = '0;
		b = ev.data_byte;

		// gap: closes an open frame with a status taken from the phase
		if (ev.req_type == REQ_GAP) begin
			if (phase == PH_IDLE)
				return 1'b0;
			r.byte_position = pos_cnt;
			r.frame_done    = 1'b1;
			r.phase_count   = phase_cnt;
			case (phase)
				PH_HEAD:    r.status = ST_SHORT_HEADER;
				PH_COUNT:   r.status = ST_BAD_COUNT;
				PH_PAYLOAD: r.status = ST_SHORT_PAYLOAD;
				PH_ECHO:    r.status = ST_SHORT_ECHO;
				PH_EXC:     r.status = ST_BAD_EXCEPTION;
				default:    r.status = ST_SHORT_CRC;
			endcase
			clear_frame();
			return 1'b1;
		end

		pos = pos_cnt;
		if (phase == PH_IDLE)
			enter_phase(PH_HEAD);
		pos_cnt   = pos_cnt + 9'd1;
		phase_cnt = phase_cnt + 8'd1;
		r.data_out      = b;
		r.byte_position = pos;

		case (phase)
			// header length follows the live direction mode
			PH_HEAD: begin
				hdr_len = rsp_mode ? int'(HDR_LEN_RSP) : int'(HDR_LEN_REQ);
				if (pos == 9'd1)
					func_code = b;
				if (int'(phase_cnt) >= hdr_len) begin
					if (!rsp_mode) begin
						if (func_code >= FC_READ_COILS && func_code <= FC_WRITE_REGISTER) begin
							crc_start = FIXED_BODY;
							enter_phase(PH_CRC);
						end else if (func_code == FC_WRITE_COILS || func_code == FC_WRITE_REGS) begin
							enter_phase(PH_COUNT);
						end else begin
							r.frame_done = 1'b1;
							r.status     = ST_UNKNOWN_CODE;
						end
					end else begin
						if ((func_code & EXC_FLAG) != 8'd0) begin
							enter_phase(PH_EXC);
						end else if (func_code >= FC_READ_COILS && func_code <= FC_READ_INPUT) begin
							enter_phase(PH_COUNT);
						end else if (func_code == FC_WRITE_COIL || func_code == FC_WRITE_REGISTER ||
							func_code == FC_WRITE_COILS || func_code == FC_WRITE_REGS) begin
							crc_start = FIXED_BODY;
							enter_phase(PH_ECHO);
						end else begin
							r.frame_done = 1'b1;
							r.status     = ST_UNKNOWN_CODE;
						end
					end
				end
			end
			// byte count bounded by the buffer limit
			PH_COUNT: begin
				reduce = rsp_mode ? int'(CNT_RED_RSP) : int'(CNT_RED_REQ);
				if (b != 8'd0 && int'(b) + reduce < int'(count_limit)) begin
					crc_start = pos + 9'd1 + 9'(b);
					enter_phase(PH_PAYLOAD);
				end else begin
					r.frame_done  = 1'b1;
					r.status      = ST_BAD_COUNT;
					r.phase_count = b;
				end
			end
			PH_PAYLOAD, PH_ECHO: begin
				if (int'(pos) + 1 >= int'(crc_start))
					enter_phase(PH_CRC);
			end
			PH_EXC: begin
				if (b == 8'd0) begin
					r.frame_done = 1'b1;
					r.status     = ST_BAD_EXCEPTION;
				end else begin
					crc_start = pos + 9'd1;
					enter_phase(PH_CRC);
				end
			end
			PH_CRC: begin
				if (phase_cnt >= CRC_LEN_CNT) begin
					r.frame_done   = 1'b1;
					r.status       = ST_OK;
					r.frame_length = crc_start + CRC_LEN;
				end
			end
			default: clear_frame();
		endcase

		if (r.frame_done)
			clear_frame();
		return 1'b1;
	endfunction

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		bit      produced;
		if (!arst_n) begin
			rsp_mode    = 1'b0;
			count_limit = BUFFER_LIMIT_RESET;
			clear_frame();
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DIRECTION_MODE)
					rsp_mode = cfg_wdata[0];
				else
					count_limit = cfg_wdata;
			end

			// compare the result transaction with the oldest prediction
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %0d: unexpected, data_out 0x%0h position %0d",
						result_count, result.data_out, result.byte_position));
				end else begin
					want = expected_results.pop_front();
					check_field("data_out", result.data_out, want.data_out);
					check_field("byte_position", result.byte_position, want.byte_position);
					check_field("frame_done", result.frame_done, want.frame_done);
					check_field("status", int'(result.status), int'(want.status));
					check_field("frame_length", result.frame_length, want.frame_length);
					check_field("phase_count", result.phase_count, want.phase_count);
				end
				result_count++;
			end

			if (item_valid && item_ready) begin
				produced = predict_frame_event(item, want);
				if (produced)
					expected_results.push_back(want);
			end

			outstanding <= expected_results.size();
		end
	end

endmodule

[bench/testbench.sv]
// top of the modbus rtu frame delimiter bench: clock, reset, stimulus, verdict
// depends on mrfd_pkg, modbus_rtu_frame_delimiter_top and mrfd_frame_checker
module testbench;
	import mrfd_pkg::*;

	localparam int BYTE_TARGET  = 1600;
	localparam int IDLE_LIMIT   = 500;
	localparam int DRAIN_CYCLES = 4;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	item_t      item_bus = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	result_t    result_bus;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [0:0] cfg_index = REG_DIRECTION_MODE;
	logic [9:0] cfg_wdata = '0;

	int         fail_count;
	int         outstanding;
	int         bytes_sent = 0;
	int         idle_cycles = 0;
	bit         sender_burst = 1'b0;
	bit         receiver_burst = 1'b0;
	logic       cur_mode = 1'b0;
	int         cur_limit = 256;
	logic [7:0] frame_bytes[$];

	always #4 clk = ~clk;

	modbus_rtu_frame_delimiter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_bus),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	mrfd_frame_checker frame_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_bus),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.outstanding  (outstanding),
		.fail_count   (fail_count)
	);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL modbus_rtu_frame_delimiter_top");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stall before each transaction
	initial begin : result_sink
		int stall;
		@(posedge clk);
		forever begin
			stall = receiver_burst ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// one event on the input channel, after a random gap
	task automatic send_event(input logic kind, input logic [7:0] value);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_bus   <= {kind, value};
		do @(posedge clk); while (!item_ready);
		if (kind == REQ_BYTE)
			bytes_sent++;
	endtask

	// wait until every predicted result is out and the pipeline is empty
	task automatic wait_for_drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write both registers once every predicted result is out
	task automatic apply_config(input logic mode, input int limit);
		wait_for_drain();
		cfg_valid <= 1'b1;
		cfg_index <= REG_DIRECTION_MODE;
		cfg_wdata <= {9'd0, mode};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_BUFFER_LIMIT;
		cfg_wdata <= 10'(limit);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_mode  = mode;
		cur_limit = limit;
	endtask

	// send the first stop_at bytes of frame_bytes, optionally closed by a gap
	task automatic send_frame(input int stop_at, input bit close_gap);
		for (int i = 0; i < stop_at; i++)
			send_event(REQ_BYTE, frame_bytes[i]);
		if (close_gap)
			send_event(REQ_GAP, 8'($urandom_range(0, 255)));
	endtask

	// build a frame for the current mode, mostly well formed
	task automatic build_frame();
		logic [7:0] fc;
		logic [7:0] exc_code;
		int         roll;
		int         max_ok;
		int         cnt;
		frame_bytes.delete();
		roll = $urandom_range(0, 99);
		frame_bytes.push_back(8'($urandom_range(0, 255)));

		// function code and the rest of the header
		if (!cur_mode) begin
			if (roll < 45)
				fc = 8'($urandom_range(FC_READ_COILS, FC_WRITE_REGISTER));
			else if (roll < 90)
				fc = $urandom_range(0, 1) ? FC_WRITE_COILS : FC_WRITE_REGS;
			else
				fc = 8'($urandom_range(0, 255));
			frame_bytes.push_back(fc);
			repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			if (roll < 40) begin
				fc = 8'($urandom_range(FC_READ_COILS, FC_READ_INPUT));
			end else if (roll < 70) begin
				case ($urandom_range(0, 3))
					0:       fc = FC_WRITE_COIL;
					1:       fc = FC_WRITE_REGISTER;
					2:       fc = FC_WRITE_COILS;
					default: fc = FC_WRITE_REGS;
				endcase
			end else if (roll < 90) begin
				fc = EXC_FLAG | 8'($urandom_range(0, 127));
			end else begin
				fc = 8'($urandom_range(0, 255));
			end
			frame_bytes.push_back(fc);
		end

		// body as the parser will see it
		if (!cur_mode && fc >= FC_READ_COILS && fc <= FC_WRITE_REGISTER) begin
		end else if ((!cur_mode && (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS)) ||
			(cur_mode && !fc[7] && fc >= FC_READ_COILS && fc <= FC_READ_INPUT)) begin
			max_ok = cur_limit - (cur_mode ? int'(CNT_RED_RSP) : int'(CNT_RED_REQ)) - 1;
			if (max_ok > 255)
				max_ok = 255;
			roll = $urandom_range(0, 99);
			if (max_ok < 1 || roll < 8) begin
				if (max_ok >= 255 || $urandom_range(0, 1))
					cnt = 0;
				else
					cnt = $urandom_range(max_ok + 1, 255);
			end else if (roll < 16) begin
				cnt = max_ok;
			end else begin
				cnt = $urandom_range(1, max_ok < 8 ? max_ok : 8);
			end
			frame_bytes.push_back(8'(cnt));
			if (cnt < 1 || cnt > max_ok)
				return;
			repeat (cnt) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (cur_mode && fc[7]) begin
			exc_code = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
			frame_bytes.push_back(exc_code);
			if (exc_code == 8'd0)
				return;
		end else if (cur_mode && (fc == FC_WRITE_COIL || fc == FC_WRITE_REGISTER ||
			fc == FC_WRITE_COILS || fc == FC_WRITE_REGS)) begin
			repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			// unknown code ends the frame at the header
			return;
		end

		// crc bytes
		repeat (2) frame_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// stimulus and verdict
	initial begin
		int  roll;
		int  limit;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: request frames at reset settings
		apply_config(1'b0, 256);
		send_event(REQ_GAP, 8'hFF);
		frame_bytes = '{8'hFF, 8'h06, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h00, 8'hFF};
		send_frame(frame_bytes.size(), 1'b0);

		// directed: responses at the smallest buffer limit
		apply_config(1'b1, 11);
		frame_bytes = '{8'h01, 8'h03, 8'h06};
		send_frame(frame_bytes.size(), 1'b0);
		frame_bytes = '{8'h01, 8'h03, 8'h00};
		send_frame(frame_bytes.size(), 1'b0);
		frame_bytes = '{8'h01, 8'h83, 8'h00};
		send_frame(frame_bytes.size(), 1'b0);

		// directed: mode switch inside a request header, then a short echo
		apply_config(1'b0, 512);
		frame_bytes = '{8'h11, 8'h05, 8'h00};
		send_frame(frame_bytes.size(), 1'b0);
		apply_config(1'b1, 512);
		frame_bytes = '{8'h00};
		send_frame(1, 1'b1);

		// directed: unknown response code, gap inside the header
		frame_bytes = '{8'h00, 8'h00, 8'h01};
		send_frame(3, 1'b1);

		// random phases with fresh settings each time
		while (bytes_sent < BYTE_TARGET) begin
			case ($urandom_range(0, 9))
				0:       limit = 11;
				1:       limit = 512;
				2:       limit = 256;
				3:       limit = 16;
				4:       limit = $urandom_range(11, 20);
				default: limit = $urandom_range(11, 512);
			endcase
			apply_config(1'($urandom_range(0, 1)), limit);
			sender_burst   = ($urandom_range(0, 3) == 0);
			receiver_burst = ($urandom_range(0, 3) == 0);

			repeat ($urandom_range(2, 10)) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					// noise, then a gap to realign
					repeat ($urandom_range(1, 6))
						send_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
					send_event(REQ_GAP, 8'($urandom_range(0, 255)));
				end else begin
					build_frame();
					if (roll < 22)
						send_frame($urandom_range(0, frame_bytes.size() - 1), 1'b1);
					else
						send_frame(frame_bytes.size(), 1'b0);
				end
			end

			// sometimes leave a frame open across the next settings change
			if ($urandom_range(0, 2) == 0) begin
				build_frame();
				send_frame($urandom_range(1, frame_bytes.size() - 1), 1'b0);
			end
		end

		wait_for_drain();
		if (fail_count == 0 && outstanding == 0)
			$display("PASS modbus_rtu_frame_delimiter_top");
		else
			$display("FAIL modbus_rtu_frame_delimiter_top");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/mrfd_pkg.sv
rtl/modbus_rtu_frame_delimiter_top.sv
bench/mrfd_frame_checker.sv
bench/testbench.sv
